// ----- design/grid_min_total_distance_bfs_defines.svh -----
// Assertion macros shared by the block
`ifndef GRID_MIN_TOTAL_DISTANCE_BFS_DEFINES_SVH
`define GRID_MIN_TOTAL_DISTANCE_BFS_DEFINES_SVH

// Assert that a property holds at every clock edge outside reset
`define GMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle
`define GMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/gmd_pkg.sv -----
package gmd_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int N_W      = 2 * DIM_W;
  localparam int CNT_W    = IDX_W + 1;
  localparam int SUM_W    = 20;
  localparam int KIND_W   = 2;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 6;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Cell codes
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HOUSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ODD   = 2'd3;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_COLS = 2'd1;

  // Per-cell word: kind, distance sum, reach count, last search tag
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  tag;
  } cell_word_t;

  // Queue word: row, column, path length
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] lvl;
  } queue_word_t;

  localparam int CELL_WORD_W  = $bits(cell_word_t);
  localparam int QUEUE_WORD_W = $bits(queue_word_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    cell_word_t       wdata;
  } cell_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    queue_word_t      wdata;
  } queue_req_t;

  typedef struct packed {
    logic in_load;
    logic q_ok;
  } status_t;

endpackage

// ----- design/gmd_ram.sv -----
module gmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; read data is registered and shows the cycle after the address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- design/gmd_ctrl.sv -----
module gmd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gmd_pkg::CFG_A_W-1:0]  cfg_addr_i,
  input  logic [gmd_pkg::CFG_D_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gmd_pkg::KIND_W-1:0]   cell_kind_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [gmd_pkg::SUM_W-1:0]    total_distance_o,
  output gmd_pkg::cell_req_t           cell_req_o,
  input  gmd_pkg::cell_word_t          cell_rdata_i,
  output gmd_pkg::queue_req_t          q_req_o,
  input  gmd_pkg::queue_word_t         q_rdata_i,
  output gmd_pkg::status_t             status_o
);

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CHK = 9'b000000100,
    S_POP_RD   = 9'b000001000,
    S_POP_CHK  = 9'b000010000,
    S_NB       = 9'b000100000,
    S_NB_CHK   = 9'b001000000,
    S_FIN_RD   = 9'b010000000,
    S_FIN_CHK  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [gmd_pkg::DIM_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [gmd_pkg::IDX_W-1:0] load_q, load_d, idx_q, idx_d;
  logic [gmd_pkg::CNT_W-1:0] houses_q, houses_d, tag_q, tag_d;
  logic [gmd_pkg::CNT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [gmd_pkg::ROW_W-1:0] sr_q, sr_d, cur_r_q, cur_r_d;
  logic [gmd_pkg::COL_W-1:0] sc_q, sc_d, cur_c_q, cur_c_d;
  logic [gmd_pkg::CNT_W-1:0] cur_d_q, cur_d_d;
  logic [1:0]                dir_q, dir_d;
  logic [gmd_pkg::ROW_W-1:0] nb_r_q, nb_r_d;
  logic [gmd_pkg::COL_W-1:0] nb_c_q, nb_c_d;
  logic                      out_valid_q, out_valid_d;
  logic                      found_q, found_d;
  logic [gmd_pkg::SUM_W-1:0] best_q, best_d;

  logic [gmd_pkg::N_W-1:0]   n_cells;
  logic [gmd_pkg::IDX_W-1:0] load_idx;
  logic                      load_last, idx_last, col_last;
  logic [gmd_pkg::KIND_W-1:0] kind_in;
  logic                      accept;
  logic                      nb_ok;
  logic [gmd_pkg::ROW_W-1:0] nr;
  logic [gmd_pkg::COL_W-1:0] nc;
  logic [gmd_pkg::N_W-1:0]   nb_addr;
  logic [gmd_pkg::SUM_W:0]   sum_ext;
  logic [gmd_pkg::DIM_W-1:0] cfg_eff_r, cfg_eff_c;

  // Clamp a written size into its legal range
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_eff_r = gmd_pkg::DIM_W'(1);
    end else if (int'(cfg_wdata_i) > gmd_pkg::MAX_ROWS) begin
      cfg_eff_r = gmd_pkg::DIM_W'(gmd_pkg::MAX_ROWS);
    end else begin
      cfg_eff_r = gmd_pkg::DIM_W'(cfg_wdata_i);
    end
    if (cfg_wdata_i == '0) begin
      cfg_eff_c = gmd_pkg::DIM_W'(1);
    end else if (int'(cfg_wdata_i) > gmd_pkg::MAX_COLS) begin
      cfg_eff_c = gmd_pkg::DIM_W'(gmd_pkg::MAX_COLS);
    end else begin
      cfg_eff_c = gmd_pkg::DIM_W'(cfg_wdata_i);
    end
  end

  assign n_cells   = rows_q * cols_q;
  assign load_idx  = (gmd_pkg::N_W'(load_q) >= n_cells) ? '0 : load_q;
  assign load_last = (gmd_pkg::N_W'(load_idx) + gmd_pkg::N_W'(1)) == n_cells;
  assign idx_last  = (gmd_pkg::N_W'(idx_q) + gmd_pkg::N_W'(1)) == n_cells;
  assign col_last  = (gmd_pkg::DIM_W'(sc_q) + gmd_pkg::DIM_W'(1)) == cols_q;
  assign kind_in   = (cell_kind_i == gmd_pkg::KIND_ODD) ? gmd_pkg::KIND_WALL : cell_kind_i;

  // Hold off the last cell while the previous result still waits
  assign in_ready_o = (state_q == S_LOAD) && !(out_valid_q && load_last);
  assign accept     = in_valid_i && in_ready_o;

  // Neighbor of the current cell in the present direction
  always_comb begin
    nr    = cur_r_q;
    nc    = cur_c_q;
    nb_ok = 1'b0;
    unique case (dir_q)
      2'd0: begin
        nc    = cur_c_q + gmd_pkg::COL_W'(1);
        nb_ok = (gmd_pkg::DIM_W'(cur_c_q) + gmd_pkg::DIM_W'(1)) < cols_q;
      end
      2'd1: begin
        nr    = cur_r_q + gmd_pkg::ROW_W'(1);
        nb_ok = (gmd_pkg::DIM_W'(cur_r_q) + gmd_pkg::DIM_W'(1)) < rows_q;
      end
      2'd2: begin
        nc    = cur_c_q - gmd_pkg::COL_W'(1);
        nb_ok = cur_c_q != '0;
      end
      2'd3: begin
        nr    = cur_r_q - gmd_pkg::ROW_W'(1);
        nb_ok = cur_r_q != '0;
      end
      default: ;
    endcase
    nb_addr = gmd_pkg::N_W'(nr) * gmd_pkg::N_W'(cols_q) + gmd_pkg::N_W'(nc);
  end

  assign sum_ext = {1'b0, cell_rdata_i.sum} + (gmd_pkg::SUM_W + 1)'(cur_d_q);

  // Sequencer: load, scan for houses, search, final sweep
  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    load_d      = load_q;
    idx_d       = idx_q;
    houses_d    = houses_q;
    tag_d       = tag_q;
    head_d      = head_q;
    tail_d      = tail_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    cur_r_d     = cur_r_q;
    cur_c_d     = cur_c_q;
    cur_d_d     = cur_d_q;
    dir_d       = dir_q;
    nb_r_d      = nb_r_q;
    nb_c_d      = nb_c_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    best_d      = best_q;
    cell_req_o  = '0;
    q_req_o     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        cell_req_o.addr = load_idx;
        if (cfg_we_i) begin
          // Drop the grid in progress on a write to the row or column register
          if (cfg_addr_i == gmd_pkg::REG_ROWS) begin
            rows_d   = cfg_eff_r;
            load_d   = '0;
            houses_d = '0;
          end else if (cfg_addr_i == gmd_pkg::REG_COLS) begin
            cols_d   = cfg_eff_c;
            load_d   = '0;
            houses_d = '0;
          end
        end else if (accept) begin
          cell_req_o.we         = 1'b1;
          cell_req_o.wdata.kind = kind_in;
          if (kind_in == gmd_pkg::KIND_HOUSE) begin
            houses_d = houses_q + gmd_pkg::CNT_W'(1);
          end
          if (load_last) begin
            load_d  = '0;
            idx_d   = '0;
            sr_d    = '0;
            sc_d    = '0;
            tag_d   = '0;
            state_d = S_SCAN_RD;
          end else begin
            load_d = load_idx + gmd_pkg::IDX_W'(1);
          end
        end
      end
      S_SCAN_RD: begin
        cell_req_o.addr = idx_q;
        state_d         = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (cell_rdata_i.kind == gmd_pkg::KIND_HOUSE) begin
          // Seed a search from this house
          q_req_o.we        = 1'b1;
          q_req_o.addr      = '0;
          q_req_o.wdata.row = sr_q;
          q_req_o.wdata.col = sc_q;
          q_req_o.wdata.lvl = '0;
          head_d            = '0;
          tail_d            = gmd_pkg::CNT_W'(1);
          tag_d             = tag_q + gmd_pkg::CNT_W'(1);
          state_d           = S_POP_RD;
        end else begin
          state_d = S_SCAN_RD;
        end
        // Advance the scan position
        if (idx_last) begin
          idx_d = '0;
          if (cell_rdata_i.kind != gmd_pkg::KIND_HOUSE) begin
            found_d = 1'b0;
            best_d  = '0;
            state_d = S_FIN_RD;
          end
        end else begin
          idx_d = idx_q + gmd_pkg::IDX_W'(1);
        end
        if (col_last) begin
          sc_d = '0;
          sr_d = sr_q + gmd_pkg::ROW_W'(1);
        end else begin
          sc_d = sc_q + gmd_pkg::COL_W'(1);
        end
      end
      S_POP_RD: begin
        q_req_o.addr = head_q[gmd_pkg::IDX_W-1:0];
        if (head_q == tail_q) begin
          // Search done: resume scan, or sweep after the last cell
          if (idx_q == '0) begin
            found_d = 1'b0;
            best_d  = '0;
            state_d = S_FIN_RD;
          end else begin
            state_d = S_SCAN_RD;
          end
        end else begin
          head_d  = head_q + gmd_pkg::CNT_W'(1);
          state_d = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        cur_r_d = q_rdata_i.row;
        cur_c_d = q_rdata_i.col;
        cur_d_d = q_rdata_i.lvl + gmd_pkg::CNT_W'(1);
        dir_d   = '0;
        state_d = S_NB;
      end
      S_NB: begin
        cell_req_o.addr = nb_addr[gmd_pkg::IDX_W-1:0];
        nb_r_d          = nr;
        nb_c_d          = nc;
        if (nb_ok) begin
          state_d = S_NB_CHK;
        end else if (dir_q == 2'd3) begin
          state_d = S_POP_RD;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      S_NB_CHK: begin
        cell_req_o.addr = nb_addr[gmd_pkg::IDX_W-1:0];
        if (cell_rdata_i.kind == gmd_pkg::KIND_EMPTY && cell_rdata_i.tag != tag_q) begin
          // Mark, accumulate and enqueue
          cell_req_o.we         = 1'b1;
          cell_req_o.wdata.kind = gmd_pkg::KIND_EMPTY;
          cell_req_o.wdata.sum  = sum_ext[gmd_pkg::SUM_W] ? gmd_pkg::SUM_MAX
                                                          : sum_ext[gmd_pkg::SUM_W-1:0];
          cell_req_o.wdata.cnt  = cell_rdata_i.cnt + gmd_pkg::CNT_W'(1);
          cell_req_o.wdata.tag  = tag_q;
          q_req_o.we            = 1'b1;
          q_req_o.addr          = tail_q[gmd_pkg::IDX_W-1:0];
          q_req_o.wdata.row     = nb_r_q;
          q_req_o.wdata.col     = nb_c_q;
          q_req_o.wdata.lvl     = cur_d_q;
          tail_d                = tail_q + gmd_pkg::CNT_W'(1);
        end
        if (dir_q == 2'd3) begin
          state_d = S_POP_RD;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = S_NB;
        end
      end
      S_FIN_RD: begin
        cell_req_o.addr = idx_q;
        state_d         = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        if (cell_rdata_i.kind == gmd_pkg::KIND_EMPTY && cell_rdata_i.cnt == houses_q) begin
          if (!found_q || cell_rdata_i.sum < best_q) begin
            best_d = cell_rdata_i.sum;
          end
          found_d = 1'b1;
        end
        if (idx_last) begin
          out_valid_d = 1'b1;
          houses_d    = '0;
          load_d      = '0;
          state_d     = S_LOAD;
        end else begin
          idx_d   = idx_q + gmd_pkg::IDX_W'(1);
          state_d = S_FIN_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      rows_q      <= gmd_pkg::DIM_W'(gmd_pkg::MAX_ROWS);
      cols_q      <= gmd_pkg::DIM_W'(gmd_pkg::MAX_COLS);
      load_q      <= '0;
      houses_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      tag_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      dir_q       <= '0;
      sr_q        <= '0;
      sc_q        <= '0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      load_q      <= load_d;
      houses_q    <= houses_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      tag_q       <= tag_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      dir_q       <= dir_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    cur_d_q <= cur_d_d;
    nb_r_q  <= nb_r_d;
    nb_c_q  <= nb_c_d;
    found_q <= found_d;
    best_q  <= best_d;
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign total_distance_o = found_q ? best_q : '0;
  assign status_o.in_load = state_q == S_LOAD;
  assign status_o.q_ok    = head_q <= tail_q;

endmodule

// ----- design/grid_min_total_distance_bfs.sv -----
// Loading: one cell word per cycle; the last cell is held while a prior result waits.
// Search: scanned cells are read, then checked; a reached cell is popped from the queue,
// then its neighbors are checked in turn, all bound by the single port of the cell memory.
// Final sweep: cells are read, then checked; the result shows the cycle after it ends.
// Reset: sizes return to 32 x 32, the grid in progress is dropped; memories need no clear.
`include "grid_min_total_distance_bfs_defines.svh"

module grid_min_total_distance_bfs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gmd_pkg::CFG_A_W-1:0] cfg_addr_i,
  input  logic [gmd_pkg::CFG_D_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gmd_pkg::KIND_W-1:0]  cell_kind_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [gmd_pkg::SUM_W-1:0]   total_distance_o
);

  gmd_pkg::cell_req_t   cell_req;
  gmd_pkg::cell_word_t  cell_rdata;
  gmd_pkg::queue_req_t  q_req;
  gmd_pkg::queue_word_t q_rdata;
  gmd_pkg::status_t     status;

  gmd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cell_kind_i      (cell_kind_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .total_distance_o (total_distance_o),
    .cell_req_o       (cell_req),
    .cell_rdata_i     (cell_rdata),
    .q_req_o          (q_req),
    .q_rdata_i        (q_rdata),
    .status_o         (status)
  );

  // Per-cell state memory
  gmd_ram #(
    .WIDTH (gmd_pkg::CELL_WORD_W),
    .DEPTH (gmd_pkg::CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_req.we),
    .addr_i  (cell_req.addr),
    .wdata_i (cell_req.wdata),
    .rdata_o (cell_rdata)
  );

  // Search queue memory
  gmd_ram #(
    .WIDTH (gmd_pkg::QUEUE_WORD_W),
    .DEPTH (gmd_pkg::CELLS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_req.we),
    .addr_i  (q_req.addr),
    .wdata_i (q_req.wdata),
    .rdata_o (q_rdata)
  );

  `GMD_ASSERT_IMPL(a_load_only, in_valid_i && in_ready_o, status.in_load, "word taken outside load")
  `GMD_ASSERT(a_queue_order, status.q_ok, "queue head passed tail")
  `GMD_ASSERT_IMPL(a_miss_zero, out_valid_o && !found_o, total_distance_o == '0, "miss with nonzero sum")

endmodule

// ----- sim/grid_min_total_distance_bfs_test.sv -----
`timescale 1ns / 1ps

module grid_min_total_distance_bfs_test;

  localparam int IDLE_LIMIT  = 2000000;
  localparam int RAND_ITEMS  = 1625;
  localparam int QUIET_ITEMS = 150;
  localparam int SETTLE      = 40;
  localparam logic [gmd_pkg::CFG_A_W-1:0] REG_SPARE = 2'd2;

  typedef struct {
    logic [gmd_pkg::SUM_W-1:0] total;
    logic                      found;
  } grid_answer_t;

  typedef struct {
    bit                          is_cfg;
    logic [gmd_pkg::CFG_A_W-1:0] addr;
    logic [gmd_pkg::CFG_D_W-1:0] data;
    logic [gmd_pkg::KIND_W-1:0]  kind;
    bit                          typed;
    logic                        t_found;
    logic [gmd_pkg::SUM_W-1:0]   t_dist;
  } step_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [gmd_pkg::CFG_A_W-1:0] cfg_addr_i;
  logic [gmd_pkg::CFG_D_W-1:0] cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [gmd_pkg::KIND_W-1:0]  cell_kind_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        found_o;
  logic [gmd_pkg::SUM_W-1:0]   total_distance_o;

  // grid shadow state
  logic [gmd_pkg::CFG_D_W-1:0] rows_reg;
  logic [gmd_pkg::CFG_D_W-1:0] cols_reg;
  logic [gmd_pkg::KIND_W-1:0]  cell_mem[gmd_pkg::CELLS];
  int                          load_pos;
  int                          house_cnt;

  grid_answer_t answer_q[$];
  int           fail_cnt;
  int           idle_cycles;
  int           items_sent;
  bit           idle_on;

  grid_min_total_distance_bfs i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cell_kind_i      (cell_kind_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .total_distance_o (total_distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int clamp_size(logic [gmd_pkg::CFG_D_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Run a search from every house and pick the best empty cell
  function automatic grid_answer_t min_total_distance(int rows, int cols);
    grid_answer_t ans;
    int dsum[gmd_pkg::CELLS];
    int reach[gmd_pkg::CELLS];
    bit seen[gmd_pkg::CELLS];
    int qpos[gmd_pkg::CELLS];
    int qlvl[gmd_pkg::CELLS];
    int dr[4] = '{0, 1, 0, -1};
    int dc[4] = '{1, 0, -1, 0};
    int n, head, tail, cur, r, c, nr, nc, ni;
    n = rows * cols;
    ans.found = 1'b0;
    ans.total = '0;
    for (int i = 0; i < n; i++) begin
      dsum[i]  = 0;
      reach[i] = 0;
    end
    for (int s = 0; s < n; s++) begin
      if (cell_mem[s] != gmd_pkg::KIND_HOUSE) continue;
      for (int i = 0; i < n; i++) seen[i] = 1'b0;
      seen[s] = 1'b1;
      qpos[0] = s;
      qlvl[0] = 0;
      head = 0;
      tail = 1;
      while (head < tail) begin
        cur = qpos[head];
        r = cur / cols;
        c = cur % cols;
        for (int k = 0; k < 4; k++) begin
          nr = r + dr[k];
          nc = c + dc[k];
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          ni = nr * cols + nc;
          if (cell_mem[ni] != gmd_pkg::KIND_EMPTY || seen[ni]) continue;
          seen[ni] = 1'b1;
          dsum[ni] = (dsum[ni] + qlvl[head] + 1 > int'(gmd_pkg::SUM_MAX))
                     ? int'(gmd_pkg::SUM_MAX) : dsum[ni] + qlvl[head] + 1;
          reach[ni]++;
          qpos[tail] = ni;
          qlvl[tail] = qlvl[head] + 1;
          tail++;
        end
        head++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (cell_mem[i] == gmd_pkg::KIND_EMPTY && reach[i] == house_cnt) begin
        if (!ans.found || dsum[i] < int'(ans.total)) ans.total = gmd_pkg::SUM_W'(dsum[i]);
        ans.found = 1'b1;
      end
    end
    return ans;
  endfunction

  // Store one cell; return 1 with the answer when the grid is complete
  function automatic bit load_cell(logic [gmd_pkg::KIND_W-1:0] kind, output grid_answer_t ans);
    int rows, cols;
    rows = clamp_size(rows_reg, gmd_pkg::MAX_ROWS);
    cols = clamp_size(cols_reg, gmd_pkg::MAX_COLS);
    if (kind == gmd_pkg::KIND_ODD) kind = gmd_pkg::KIND_WALL;
    if (load_pos >= rows * cols) load_pos = 0;
    cell_mem[load_pos] = kind;
    if (kind == gmd_pkg::KIND_HOUSE) house_cnt++;
    load_pos++;
    if (load_pos < rows * cols) return 1'b0;
    ans = min_total_distance(rows, cols);
    load_pos  = 0;
    house_cnt = 0;
    return 1'b1;
  endfunction

  // Write one register once the block has drained
  task automatic write_reg(logic [gmd_pkg::CFG_A_W-1:0] addr,
                           logic [gmd_pkg::CFG_D_W-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (addr == gmd_pkg::REG_ROWS || addr == gmd_pkg::REG_COLS) begin
      if (addr == gmd_pkg::REG_ROWS) rows_reg = data;
      else cols_reg = data;
      load_pos  = 0;
      house_cnt = 0;
    end
  endtask

  // Offer one cell word and hold it until accepted
  task automatic send_cell(logic [gmd_pkg::KIND_W-1:0] kind, bit typed, logic t_found,
                           logic [gmd_pkg::SUM_W-1:0] t_dist);
    grid_answer_t ans;
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(15, 1);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    cell_kind_i = kind;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (load_cell(kind, ans)) begin
      if (typed) begin
        ans.found = t_found;
        ans.total = t_dist;
      end
      answer_q.push_back(ans);
    end
  endtask

  function automatic logic [gmd_pkg::KIND_W-1:0] pick_kind(int house_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < house_pct) return gmd_pkg::KIND_HOUSE;
    if (roll < house_pct + 20) return gmd_pkg::KIND_WALL;
    if (roll < house_pct + 25) return gmd_pkg::KIND_ODD;
    return gmd_pkg::KIND_EMPTY;
  endfunction

  // Drive the stimulus: directed table first, then random grids
  initial begin
    step_row_t plan[$];
    int grid_no, rows, cols, n, hp;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = gmd_pkg::REG_ROWS;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cell_kind_i = gmd_pkg::KIND_EMPTY;
    rows_reg    = 6'd32;
    cols_reg    = 6'd32;
    load_pos    = 0;
    house_cnt   = 0;
    items_sent  = 0;
    idle_on     = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single cell: empty, house, odd code
    plan.push_back('{1, gmd_pkg::REG_ROWS, 6'd1, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{1, gmd_pkg::REG_COLS, 6'd1, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 1, 1, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 1, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_ODD, 1, 0, 0});
    // zero rows acts as one
    plan.push_back('{1, gmd_pkg::REG_ROWS, 6'd0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{1, gmd_pkg::REG_COLS, 6'd2, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 1, 1, 1});
    // walled-in house
    plan.push_back('{1, gmd_pkg::REG_ROWS, 6'd2, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_WALL, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_ODD, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 1, 0, 0});
    // two houses on a diagonal
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 1, 1, 2});
    // partial grid dropped by a register write; spare index ignored
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{1, REG_SPARE, 6'd63, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{1, gmd_pkg::REG_COLS, 6'd3, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_HOUSE, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_WALL, 0, 0, 0});
    plan.push_back('{0, gmd_pkg::REG_ROWS, 0, gmd_pkg::KIND_EMPTY, 0, 0, 0});
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].addr, plan[i].data);
      else send_cell(plan[i].kind, plan[i].typed, plan[i].t_found, plan[i].t_dist);
    end

    // random grids, mostly small, a few at the size limits
    grid_no = 0;
    while (items_sent < RAND_ITEMS) begin
      if (grid_no == 12) begin
        rows = 32;
        cols = 32;
        hp   = 0;
        write_reg(gmd_pkg::REG_ROWS, 6'd32);
        write_reg(gmd_pkg::REG_COLS, $urandom_range(1) ? 6'd32 : 6'd63);
      end else if ($urandom_range(1) == 0 || grid_no == 13) begin
        if ($urandom_range(9) == 0) begin
          rows = $urandom_range(1) ? 0 : $urandom_range(63, 33);
          cols = $urandom_range(2);
        end else begin
          rows = $urandom_range(6, 1);
          cols = $urandom_range(6, 1);
        end
        if ($urandom_range(1)) begin
          write_reg(gmd_pkg::REG_ROWS, gmd_pkg::CFG_D_W'(rows));
          write_reg(gmd_pkg::REG_COLS, gmd_pkg::CFG_D_W'(cols));
        end else begin
          write_reg(gmd_pkg::REG_COLS, gmd_pkg::CFG_D_W'(cols));
          write_reg(gmd_pkg::REG_ROWS, gmd_pkg::CFG_D_W'(rows));
        end
      end
      rows = clamp_size(rows_reg, gmd_pkg::MAX_ROWS);
      cols = clamp_size(cols_reg, gmd_pkg::MAX_COLS);
      n    = rows * cols;
      if (grid_no != 12) hp = (n > 64) ? 2 : $urandom_range(40, 5);
      if (grid_no == 20) begin
        // hold off until the block has drained
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (answer_q.size() != 0) @(negedge clk_i);
      end
      for (int i = 0; i < n; i++) begin
        if (items_sent >= RAND_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
        if (grid_no == 12 && $urandom_range(199) == 0) begin
          send_cell(gmd_pkg::KIND_HOUSE, 0, 0, 0);
        end else if (grid_no == 12) begin
          send_cell(pick_kind(0), 0, 0, 0);
        end else begin
          send_cell(pick_kind(hp), 0, 0, 0);
        end
      end
      grid_no++;
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // drain, then settle
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stall the result side in random bursts
  initial begin
    int gap;
    out_ready_i = 1'b0;
    fail_cnt    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(5) == 0) begin
        gap = $urandom_range(15, 1);
        out_ready_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Compare each result word with the oldest expected answer
  always @(posedge clk_i) begin
    grid_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result found=%0b total=%0d", $time, found_o,
                 total_distance_o);
        fail_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, found_o);
          fail_cnt++;
        end
        if (total_distance_o !== want.total) begin
          $display("%0t: total_distance expected %0d actual %0d", $time, want.total,
                   total_distance_o);
          fail_cnt++;
        end
      end
    end
  end

  // Count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+design
design/gmd_pkg.sv
design/gmd_ram.sv
design/gmd_ctrl.sv
design/grid_min_total_distance_bfs.sv
sim/grid_min_total_distance_bfs_test.sv
